// ===== design/bss_pkg.sv =====
// ----------------------------------------------------------------------------
// bss_pkg
// shared widths, result codes and helpers of the box submersion sampler
// ----------------------------------------------------------------------------
package bss_pkg;

    localparam int XW             = 32;
    localparam int PW             = 35;
    localparam int DVW            = PW + 1;
    localparam int QW             = DVW + 16;
    localparam int RW             = 3;
    localparam int FW             = 17;
    localparam int DIVISIONS_DEF  = 4;

    localparam logic [1:0] SIT_OUT  = 2'd0;
    localparam logic [1:0] SIT_PART = 2'd1;
    localparam logic [1:0] SIT_FULL = 2'd2;

    function automatic int lat_div(input int n);
        lat_div = (n > 1) ? n - 1 : 1;
    endfunction

endpackage

// ===== design/box_submersion_sampler.sv =====
// ----------------------------------------------------------------------------
// box_submersion_sampler
// samples a lattice over an oriented box and reports how deep it sits in water
//
//   channel   direction   handshake               payload
//   input     in          i_valid / o_stall       i_center_*, i_axis_*
//   result    out         o_valid / i_stall       o_situation .. o_mean_z
//   config    in          i_cfg_valid / o_cfg_ready  i_cfg_data (water level)
//
// one box per cycle while the result is not stalled; stages: input register,
// 2 axis division stages, 3 + clog2(DIVISIONS^3) lattice and sum tree stages,
// divider setup, the 52-stage divider and the output register
// reset clears all valid bits and sets the water level to zero
// a stalled result freezes the whole pipeline, nothing is dropped
// ----------------------------------------------------------------------------
module box_submersion_sampler #(
    parameter int DIVISIONS = bss_pkg::DIVISIONS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [31:0]        i_center_x,
    input  logic signed [31:0]        i_center_y,
    input  logic signed [31:0]        i_center_z,
    input  logic signed [31:0]        i_axis_u_x,
    input  logic signed [31:0]        i_axis_u_y,
    input  logic signed [31:0]        i_axis_u_z,
    input  logic signed [31:0]        i_axis_v_x,
    input  logic signed [31:0]        i_axis_v_y,
    input  logic signed [31:0]        i_axis_v_z,
    input  logic signed [31:0]        i_axis_w_x,
    input  logic signed [31:0]        i_axis_w_y,
    input  logic signed [31:0]        i_axis_w_z,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [31:0]               i_cfg_data,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [1:0]                o_situation,
    output logic [16:0]               o_depth_fraction,
    output logic [6:0]                o_points_under,
    output logic signed [31:0]        o_mean_x,
    output logic signed [31:0]        o_mean_y,
    output logic signed [31:0]        o_mean_z
);

    localparam int PW  = bss_pkg::PW;
    localparam int QW  = bss_pkg::QW;
    localparam int DVW = bss_pkg::DVW;
    localparam int NP  = DIVISIONS * DIVISIONS * DIVISIONS;
    localparam int LV  = $clog2(NP);
    localparam int SW  = PW + LV;
    localparam int CW  = LV + 1;

    typedef struct packed {
        logic signed [31:0]   cx;
        logic signed [31:0]   cy;
        logic signed [31:0]   cz;
        logic signed [PW-1:0] ymin;
        logic signed [PW-1:0] ymax;
    } t_box_sb;

    typedef struct packed {
        logic signed [PW-1:0] ymin;
        logic signed [PW-1:0] ymax;
    } t_span;

    typedef struct packed {
        logic [1:0]    sit;
        logic [CW-1:0] cnt;
        logic [2:0]    neg;
    } t_res_sb;

    function automatic logic signed [31:0] sat32(input logic signed [QW+1:0] v);
        if (v > (QW+2)'(32'sh7fff_ffff)) begin
            sat32 = 32'sh7fff_ffff;
        end else if (v < -(QW+2)'(64'sh8000_0000)) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = 32'(v);
        end
    endfunction

    function automatic logic [32:0] abs33(input logic signed [31:0] x);
        abs33 = x[31] ? 33'(-33'(x)) : 33'(x);
    endfunction

    logic               adv;
    logic signed [31:0] r_water_level;
    logic               r_in_valid;
    logic signed [31:0] r_in [12];
    t_box_sb            box_sb;
    logic [PW-1:0]      asum;

    logic               ad_valid;
    logic signed [31:0] ad_x [9];
    logic signed [31:0] ad_q [9];
    logic [bss_pkg::RW-1:0] ad_r [9];
    logic [$bits(t_box_sb)-1:0] ad_sb;
    t_box_sb            ad_box;

    logic signed [31:0] lt_c [3];
    logic signed [31:0] lt_q [3][3];
    logic [bss_pkg::RW-1:0] lt_r [3][3];
    t_span              lt_span_in;
    logic               lt_valid;
    logic signed [SW-1:0] lt_sum [3];
    logic [CW-1:0]      lt_count;
    logic [$bits(t_span)-1:0] lt_sb;
    t_span              lt_span;

    logic               r_p_valid;
    logic [QW-1:0]      r_p_a [4];
    logic [DVW-1:0]     r_p_d [4];
    t_res_sb            r_p_sb;
    logic [DVW-1:0]     num, den;
    logic [SW:0]        mag [3];
    logic [1:0]         n_sit;

    logic               dv_valid;
    logic [QW-1:0]      dv_q [4];
    logic [3:0]         dv_rem_nz;
    logic [$bits(t_res_sb)-1:0] dv_sb;
    t_res_sb            dv_res;
    logic signed [QW+1:0] mval [3];

    logic               r_out_valid;
    logic [1:0]         r_out_sit;
    logic [16:0]        r_out_frac;
    logic [6:0]         r_out_cnt;
    logic signed [31:0] r_out_mean [3];

    assign adv         = !(r_out_valid && i_stall);
    assign o_stall     = r_out_valid && i_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_water_level <= '0;
        end else if (i_cfg_valid) begin
            r_water_level <= $signed(i_cfg_data);
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (adv) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_in <= '{i_center_x, i_center_y, i_center_z,
                      i_axis_u_x, i_axis_u_y, i_axis_u_z,
                      i_axis_v_x, i_axis_v_y, i_axis_v_z,
                      i_axis_w_x, i_axis_w_y, i_axis_w_z};
        end
    end

    // height span comes from the corners
    always_comb begin
        asum        = PW'(abs33(r_in[4])) + PW'(abs33(r_in[7])) + PW'(abs33(r_in[10]));
        box_sb.cx   = r_in[0];
        box_sb.cy   = r_in[1];
        box_sb.cz   = r_in[2];
        box_sb.ymin = PW'(r_in[1]) - $signed(asum);
        box_sb.ymax = PW'(r_in[1]) + $signed(asum);
        for (int n = 0; n < 9; n++) begin
            ad_x[n] = r_in[3+n];
        end
    end

    bss_adiv #(
        .DIVISIONS (DIVISIONS),
        .SBW       ($bits(t_box_sb))
    ) u_adiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_in_valid),
        .i_x     (ad_x),
        .i_sb    (box_sb),
        .o_valid (ad_valid),
        .o_q     (ad_q),
        .o_r     (ad_r),
        .o_sb    (ad_sb)
    );

    always_comb begin
        ad_box          = t_box_sb'(ad_sb);
        lt_c[0]         = ad_box.cx;
        lt_c[1]         = ad_box.cy;
        lt_c[2]         = ad_box.cz;
        lt_span_in.ymin = ad_box.ymin;
        lt_span_in.ymax = ad_box.ymax;
        for (int ax = 0; ax < 3; ax++) begin
            for (int co = 0; co < 3; co++) begin
                lt_q[ax][co] = ad_q[ax*3+co];
                lt_r[ax][co] = ad_r[ax*3+co];
            end
        end
    end

    bss_lattice #(
        .DIVISIONS (DIVISIONS),
        .SBW       ($bits(t_span)),
        .LV        (LV),
        .SW        (SW),
        .CW        (CW)
    ) u_lattice (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (ad_valid),
        .i_c     (lt_c),
        .i_q     (lt_q),
        .i_r     (lt_r),
        .i_level (r_water_level),
        .i_sb    (lt_span_in),
        .o_valid (lt_valid),
        .o_sum   (lt_sum),
        .o_count (lt_count),
        .o_sb    (lt_sb)
    );

    // classify and set up the divisions
    always_comb begin
        lt_span = t_span'(lt_sb);
        num     = DVW'(DVW'(r_water_level) - DVW'(lt_span.ymin));
        den     = DVW'(DVW'(lt_span.ymax) - DVW'(lt_span.ymin));
        if (lt_count == CW'(NP)) begin
            n_sit = bss_pkg::SIT_FULL;
        end else if (lt_count == '0) begin
            n_sit = bss_pkg::SIT_OUT;
        end else begin
            n_sit = bss_pkg::SIT_PART;
        end
        for (int co = 0; co < 3; co++) begin
            mag[co] = lt_sum[co][SW-1] ? (SW+1)'(-(SW+1)'(lt_sum[co]))
                                       : (SW+1)'(lt_sum[co]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (adv) begin
            r_p_valid <= lt_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p_a[0]   <= {num, 16'b0};
            r_p_d[0]   <= den;
            for (int co = 0; co < 3; co++) begin
                r_p_a[co+1]   <= QW'(mag[co]);
                r_p_d[co+1]   <= DVW'(lt_count);
                r_p_sb.neg[co] <= lt_sum[co][SW-1];
            end
            r_p_sb.sit <= n_sit;
            r_p_sb.cnt <= lt_count;
        end
    end

    bss_div #(
        .LANES (4),
        .NW    (QW),
        .DW    (DVW),
        .SBW   ($bits(t_res_sb))
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (adv),
        .i_valid  (r_p_valid),
        .i_a      (r_p_a),
        .i_d      (r_p_d),
        .i_sb     (r_p_sb),
        .o_valid  (dv_valid),
        .o_q      (dv_q),
        .o_rem_nz (dv_rem_nz),
        .o_sb     (dv_sb)
    );

    // floor of negative means rounds away from zero
    always_comb begin
        dv_res = t_res_sb'(dv_sb);
        for (int co = 0; co < 3; co++) begin
            mval[co] = dv_res.neg[co]
                ? -$signed((QW+2)'(dv_q[co+1]) + (QW+2)'(dv_rem_nz[co+1]))
                :  $signed((QW+2)'(dv_q[co+1]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && dv_valid) begin
            r_out_sit <= dv_res.sit;
            r_out_cnt <= 7'(dv_res.cnt);
            case (dv_res.sit)
                bss_pkg::SIT_FULL: r_out_frac <= 17'h10000;
                bss_pkg::SIT_PART: r_out_frac <= dv_q[0][16:0];
                default:           r_out_frac <= '0;
            endcase
            for (int co = 0; co < 3; co++) begin
                r_out_mean[co] <= (dv_res.cnt == '0) ? '0 : sat32(mval[co]);
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_situation      = r_out_sit;
    assign o_depth_fraction = r_out_frac;
    assign o_points_under   = r_out_cnt;
    assign o_mean_x         = r_out_mean[0];
    assign o_mean_y         = r_out_mean[1];
    assign o_mean_z         = r_out_mean[2];

    a_stall_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("stall raised without a pending result");

    a_full_fraction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_situation == bss_pkg::SIT_FULL |-> o_depth_fraction == 17'h10000)
        else $error("submerged result without full fraction");

    a_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_situation == bss_pkg::SIT_OUT
            |-> o_depth_fraction == '0 && o_points_under == '0 && o_mean_y == '0)
        else $error("dry result carries underwater data");

    a_part_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_situation == bss_pkg::SIT_PART |-> o_depth_fraction <= 17'h10000)
        else $error("partial fraction above one");

endmodule

// ===== design/bss_adiv.sv =====
// ----------------------------------------------------------------------------
// bss_adiv
// two-stage floor division of the nine axis components by the lattice step
// ----------------------------------------------------------------------------
module bss_adiv #(
    parameter int DIVISIONS = bss_pkg::DIVISIONS_DEF,
    parameter int SBW       = 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic signed [bss_pkg::XW-1:0]     i_x [9],
    input  logic [SBW-1:0]                    i_sb,
    output logic                              o_valid,
    output logic signed [bss_pkg::XW-1:0]     o_q [9],
    output logic [bss_pkg::RW-1:0]            o_r [9],
    output logic [SBW-1:0]                    o_sb
);

    localparam int D  = bss_pkg::lat_div(DIVISIONS);
    localparam int MW = 36;
    localparam int SH = 35;
    localparam int RW = bss_pkg::RW;
    localparam logic [MW-1:0] RECIP = MW'(((64'd1 << SH) + 64'(D) - 64'd1) / 64'(D));
    localparam logic [31:0]   QB    = 32'((64'd1 << 31) / 64'(D));
    localparam logic [RW:0]   RB    = (RW+1)'((64'd1 << 31) % 64'(D));

    logic [67:0]     r_prod [9];
    logic [31:0]     r_x    [9];
    logic            r_va, r_vb;
    logic [SBW-1:0]  r_sba, r_sbb;
    logic [31:0]     qx     [9];
    logic [34:0]     rx     [9];
    logic [RW:0]     rxs    [9];
    logic            lt     [9];
    logic signed [31:0] n_q [9];
    logic [RW-1:0]   n_r    [9];
    logic signed [31:0] r_q [9];
    logic [RW-1:0]   r_r    [9];

    always_comb begin
        for (int n = 0; n < 9; n++) begin
            qx[n]  = r_prod[n][SH+31:SH];
            rx[n]  = 35'(r_x[n]) - 35'(qx[n]) * 35'(D);
            rxs[n] = rx[n][RW:0];
            lt[n]  = rxs[n] < RB;
            n_q[n] = 32'(33'(qx[n]) - 33'(QB) - 33'(lt[n]));
            n_r[n] = lt[n] ? RW'(rxs[n] + (RW+1)'(D) - RB) : RW'(rxs[n] - RB);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int n = 0; n < 9; n++) begin
                // offset by half range so the multiply stays unsigned
                r_x[n]    <= {~i_x[n][31], i_x[n][30:0]};
                r_prod[n] <= 68'({~i_x[n][31], i_x[n][30:0]}) * 68'(RECIP);
                r_q[n]    <= n_q[n];
                r_r[n]    <= n_r[n];
            end
            r_sba <= i_sb;
            r_sbb <= r_sba;
        end
    end

    assign o_valid = r_vb;
    assign o_q     = r_q;
    assign o_r     = r_r;
    assign o_sb    = r_sbb;

endmodule

// ===== design/bss_lattice.sv =====
// ----------------------------------------------------------------------------
// bss_lattice
// lattice point lanes, water test and registered sum and count tree
// ----------------------------------------------------------------------------
module bss_lattice #(
    parameter int DIVISIONS = bss_pkg::DIVISIONS_DEF,
    parameter int SBW       = 1,
    parameter int LV        = 6,
    parameter int SW        = bss_pkg::PW + LV,
    parameter int CW        = LV + 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic signed [bss_pkg::XW-1:0]     i_c [3],
    input  logic signed [bss_pkg::XW-1:0]     i_q [3][3],
    input  logic [bss_pkg::RW-1:0]            i_r [3][3],
    input  logic signed [bss_pkg::XW-1:0]     i_level,
    input  logic [SBW-1:0]                    i_sb,
    output logic                              o_valid,
    output logic signed [SW-1:0]              o_sum [3],
    output logic [CW-1:0]                     o_count,
    output logic [SBW-1:0]                    o_sb
);

    localparam int N    = DIVISIONS;
    localparam int D    = bss_pkg::lat_div(DIVISIONS);
    localparam int NP   = N * N * N;
    localparam int NL   = 1 << LV;
    localparam int NST  = 3 + LV;
    localparam int PW   = bss_pkg::PW;
    localparam int TW   = 10;
    localparam int K3   = 3 * D;
    localparam int OFF  = 3 * D * D;
    localparam int FSH  = 12;
    localparam int FRE  = ((1 << FSH) + D - 1) / D;

    function automatic logic signed [TW-1:0] floor_small(input logic signed [TW-1:0] ts);
        logic [TW-1:0] x;
        logic [21:0]   pr;
        x  = TW'(ts + TW'(OFF));
        pr = 22'(x) * 22'(FRE);
        floor_small = TW'(pr[21:FSH]) - TW'(K3);
    endfunction

    logic signed [PW-1:0] r_tq  [3][N][3];
    logic signed [TW-1:0] r_tr  [3][N][3];
    logic signed [PW-1:0] r_c1  [3];
    logic signed [PW-1:0] r_big [NP][3];
    logic signed [TW-1:0] r_fl  [NP][3];
    logic signed [PW-1:0] n_p   [NP][3];
    logic signed [SW-1:0] r_s   [1:2*NL-1][3];
    logic [CW-1:0]        r_n   [1:2*NL-1];
    logic                 r_vld [NST];
    logic [SBW-1:0]       r_sb  [NST];

    always_comb begin
        for (int l = 0; l < NP; l++) begin
            for (int co = 0; co < 3; co++) begin
                n_p[l][co] = r_big[l][co] + PW'(r_fl[l][co]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NST; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int s = 1; s < NST; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sb[0] <= i_sb;
            for (int s = 1; s < NST; s++) begin
                r_sb[s] <= r_sb[s-1];
            end
            // per-index terms of each axis
            for (int co = 0; co < 3; co++) begin
                r_c1[co] <= PW'(i_c[co]);
                for (int ax = 0; ax < 3; ax++) begin
                    for (int id = 0; id < N; id++) begin
                        r_tq[ax][id][co] <= PW'(2 * id - D) * PW'(i_q[ax][co]);
                        r_tr[ax][id][co] <= TW'(2 * id - D) * TW'($signed({1'b0, i_r[ax][co]}));
                    end
                end
            end
            // lattice lanes
            for (int i = 0; i < N; i++) begin
                for (int j = 0; j < N; j++) begin
                    for (int k = 0; k < N; k++) begin
                        for (int co = 0; co < 3; co++) begin
                            r_big[(i*N+j)*N+k][co] <= r_c1[co] + r_tq[0][i][co]
                                                    + r_tq[1][j][co] + r_tq[2][k][co];
                            r_fl[(i*N+j)*N+k][co]  <= floor_small(r_tr[0][i][co]
                                                    + r_tr[1][j][co] + r_tr[2][k][co]);
                        end
                    end
                end
            end
            // tree leaves
            for (int l = 0; l < NL; l++) begin
                if (l < NP && n_p[l][1] < PW'(i_level)) begin
                    r_n[NL+l] <= CW'(1);
                    for (int co = 0; co < 3; co++) begin
                        r_s[NL+l][co] <= SW'(n_p[l][co]);
                    end
                end else begin
                    r_n[NL+l] <= '0;
                    for (int co = 0; co < 3; co++) begin
                        r_s[NL+l][co] <= '0;
                    end
                end
            end
            // tree nodes
            for (int n = 1; n < NL; n++) begin
                r_n[n] <= r_n[2*n] + r_n[2*n+1];
                for (int co = 0; co < 3; co++) begin
                    r_s[n][co] <= r_s[2*n][co] + r_s[2*n+1][co];
                end
            end
        end
    end

    assign o_valid = r_vld[NST-1];
    assign o_sb    = r_sb[NST-1];
    assign o_count = r_n[1];
    assign o_sum   = r_s[1];

endmodule

// ===== design/bss_div.sv =====
// ----------------------------------------------------------------------------
// bss_div
// pipelined restoring divider, one quotient bit per stage, several lanes
// ----------------------------------------------------------------------------
module bss_div #(
    parameter int LANES = 4,
    parameter int NW    = bss_pkg::QW,
    parameter int DW    = bss_pkg::DVW,
    parameter int SBW   = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [NW-1:0]         i_a [LANES],
    input  logic [DW-1:0]         i_d [LANES],
    input  logic [SBW-1:0]        i_sb,
    output logic                  o_valid,
    output logic [NW-1:0]         o_q [LANES],
    output logic [LANES-1:0]      o_rem_nz,
    output logic [SBW-1:0]        o_sb
);

    logic [NW-1:0]  r_aq  [NW][LANES];
    logic [DW-1:0]  r_r   [NW][LANES];
    logic [DW-1:0]  r_d   [NW][LANES];
    logic           r_vld [NW];
    logic [SBW-1:0] r_sb  [NW];
    logic [NW-1:0]  s_aq  [NW][LANES];
    logic [DW-1:0]  s_r   [NW][LANES];
    logic [DW-1:0]  s_d   [NW][LANES];
    logic [DW:0]    rr    [NW][LANES];
    logic           ge    [NW][LANES];

    always_comb begin
        for (int s = 0; s < NW; s++) begin
            for (int l = 0; l < LANES; l++) begin
                s_aq[s][l] = (s == 0) ? i_a[l] : r_aq[(s == 0) ? 0 : s-1][l];
                s_r[s][l]  = (s == 0) ? '0     : r_r[(s == 0) ? 0 : s-1][l];
                s_d[s][l]  = (s == 0) ? i_d[l] : r_d[(s == 0) ? 0 : s-1][l];
                rr[s][l]   = {s_r[s][l], s_aq[s][l][NW-1]};
                ge[s][l]   = rr[s][l] >= {1'b0, s_d[s][l]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NW; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int s = 1; s < NW; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sb[0] <= i_sb;
            for (int s = 1; s < NW; s++) begin
                r_sb[s] <= r_sb[s-1];
            end
            for (int s = 0; s < NW; s++) begin
                for (int l = 0; l < LANES; l++) begin
                    r_aq[s][l] <= {s_aq[s][l][NW-2:0], ge[s][l]};
                    r_r[s][l]  <= ge[s][l] ? DW'(rr[s][l] - {1'b0, s_d[s][l]})
                                           : DW'(rr[s][l]);
                    r_d[s][l]  <= s_d[s][l];
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_q[l]      = r_aq[NW-1][l];
            o_rem_nz[l] = |r_r[NW-1][l];
        end
    end

    assign o_valid = r_vld[NW-1];
    assign o_sb    = r_sb[NW-1];

endmodule
